@@ hw/rtl/hftc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the heater / fan thermal controller.
// Register map, field widths and fixed thresholds. No dependencies.
package hftc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam int WTEMP_W = 8;
	localparam int ATEMP_W = 11;
	localparam int LEVEL_W = 2;
	localparam int CNT_W   = 3;

	// register index, paddr[3:2]
	typedef enum logic [1:0] {
		REG_WATER_LIMIT   = 2'd0,
		REG_CUSTOM_AIR    = 2'd1,
		REG_STORAGE_LEVEL = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	// storage level codes
	typedef enum logic [LEVEL_W-1:0] {
		LEVEL_LOW    = 2'd0,
		LEVEL_MID    = 2'd1,
		LEVEL_CUSTOM = 2'd2,
		LEVEL_ALT    = 2'd3
	} level_t;

	typedef enum logic [1:0] {
		FAN_OFF  = 2'd0,
		FAN_LOW  = 2'd1,
		FAN_MID  = 2'd2,
		FAN_HIGH = 2'd3
	} fan_speed_t;

	localparam logic [WTEMP_W-1:0] WATER_LIMIT_RST = 8'd60;
	localparam logic [ATEMP_W-1:0] CUSTOM_AIR_RST  = 11'd700;

	localparam logic [ATEMP_W-1:0] AIR_LIMIT_LOW = 11'd350;
	localparam logic [ATEMP_W-1:0] AIR_LIMIT_MID = 11'd550;
	localparam logic [ATEMP_W-1:0] FAN_AIR_HIGH  = 11'd350;
	localparam logic [ATEMP_W-1:0] FAN_AIR_MID   = 11'd500;
	localparam logic [ATEMP_W:0]   HEAT_HYST     = 12'd10;
	localparam logic [WTEMP_W:0]   WATER_MARGIN  = 9'd5;
	localparam logic [CNT_W-1:0]   CLEAR_TICKS   = 3'd5;
	localparam logic [CNT_W-1:0]   FAN_DEBOUNCE  = 3'd5;

endpackage

@@ hw/rtl/heater_fan_thermal_controller_core.sv @@
`timescale 1ns / 1ps
// Heater / fan thermal controller: one control tick per transfer.
// An input transfer passes the input register, then the state and result registers.
// Throughput: one tick per cycle unless out_ready stalls; the single state update sets it.
// Reset: arst_n clears all control state, the alarm and fan state and the valid bits;
// configuration returns to water_limit 60, custom_air_limit 700, storage_level 0.
// Depends on hftc_pkg.
module heater_fan_thermal_controller_core
	import hftc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// APB configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [WTEMP_W-1:0]  water_temp,
	input  logic [ATEMP_W-1:0]  air_temp,
	input  logic                water_alarm_pin,
	input  logic                heat_alarm_pin,
	input  logic                release_enable,
	input  logic                storage_enable,
	// result channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic                heater_on,
	output logic [1:0]          fan_speed,
	output logic                water_pump_on,
	output logic                air_motor_on,
	output logic                water_alarm,
	output logic                heat_alarm
);

	// configuration registers
	logic [WTEMP_W-1:0] water_limit_q;
	logic [ATEMP_W-1:0] custom_air_q;
	logic [LEVEL_W-1:0] storage_level_q;

	reg_idx_t reg_idx;
	logic     cfg_wr;

	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			water_limit_q   <= WATER_LIMIT_RST;
			custom_air_q    <= CUSTOM_AIR_RST;
			storage_level_q <= LEVEL_W'(LEVEL_LOW);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WATER_LIMIT:   water_limit_q   <= pwdata[WTEMP_W-1:0];
				REG_CUSTOM_AIR:    custom_air_q    <= pwdata[ATEMP_W-1:0];
				REG_STORAGE_LEVEL: storage_level_q <= pwdata[LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_WATER_LIMIT:   prdata = DATA_W'(water_limit_q);
			REG_CUSTOM_AIR:    prdata = DATA_W'(custom_air_q);
			REG_STORAGE_LEVEL: prdata = DATA_W'(storage_level_q);
			default:           prdata = '0;
		endcase
	end

	// input register
	logic               valid_s1;
	logic [WTEMP_W-1:0] water_s1;
	logic [ATEMP_W-1:0] air_s1;
	logic               wpin_s1;
	logic               hpin_s1;
	logic               release_s1;
	logic               storage_s1;

	logic out_valid_q;
	logic advance;

	assign advance  = valid_s1 & (~out_valid_q | out_ready);
	assign in_ready = ~valid_s1 | advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			water_s1   <= water_temp;
			air_s1     <= air_temp;
			wpin_s1    <= water_alarm_pin;
			hpin_s1    <= heat_alarm_pin;
			release_s1 <= release_enable;
			storage_s1 <= storage_enable;
		end
	end

	// controller state
	logic             walarm_q, halarm_q, heater_q, fan_active_q, last_rel_q;
	logic [CNT_W-1:0] wcnt_q, hcnt_q, fcnt_q;
	logic [1:0]       fspeed_q;

	logic             walarm_d, halarm_d, heater_d, fan_active_d, last_rel_d;
	logic [CNT_W-1:0] wcnt_d, hcnt_d, fcnt_d;
	logic [1:0]       fspeed_d;

	logic [ATEMP_W-1:0] air_limit;
	logic [ATEMP_W:0]   air_plus;
	logic [WTEMP_W:0]   water_plus;
	logic [WTEMP_W:0]   wlim_ext;
	logic [1:0]         target;

	always_comb begin
		case (level_t'(storage_level_q))
			LEVEL_LOW: air_limit = AIR_LIMIT_LOW;
			LEVEL_MID: air_limit = AIR_LIMIT_MID;
			default:   air_limit = custom_air_q;
		endcase
	end

	assign air_plus   = {1'b0, air_s1} + HEAT_HYST;
	assign water_plus = {1'b0, water_s1} + WATER_MARGIN;
	assign wlim_ext   = {1'b0, water_limit_q};

	always_comb begin
		if (air_s1 <= FAN_AIR_HIGH)
			target = 2'(FAN_HIGH);
		else if (air_s1 <= FAN_AIR_MID)
			target = 2'(FAN_MID);
		else
			target = 2'(FAN_LOW);
	end

	always_comb begin
		walarm_d     = walarm_q;
		wcnt_d       = wcnt_q;
		halarm_d     = halarm_q;
		hcnt_d       = hcnt_q;
		heater_d     = heater_q;
		fan_active_d = fan_active_q;
		last_rel_d   = last_rel_q;
		fspeed_d     = fspeed_q;
		fcnt_d       = fcnt_q;

		// water alarm: set at once, clear after a run of ticks below the limit
		if (!walarm_q) begin
			if (water_s1 > water_limit_q)
				walarm_d = 1'b1;
		end else if (water_s1 < water_limit_q) begin
			if (wcnt_q < CLEAR_TICKS)
				wcnt_d = wcnt_q + 1'b1;
			else
				walarm_d = 1'b0;
		end else begin
			wcnt_d = '0;
		end
		if (!walarm_d)
			walarm_d = wpin_s1;

		// air alarm, same scheme
		if (!halarm_q) begin
			if (air_s1 > air_limit)
				halarm_d = 1'b1;
		end else if (air_s1 < air_limit) begin
			if (hcnt_q < CLEAR_TICKS)
				hcnt_d = hcnt_q + 1'b1;
			else
				halarm_d = 1'b0;
		end else begin
			hcnt_d = '0;
		end
		if (!halarm_d)
			halarm_d = hpin_s1;

		// heater with hysteresis
		if (!storage_s1 || halarm_d)
			heater_d = 1'b0;
		else if (!heater_q) begin
			if (air_plus <= {1'b0, air_limit})
				heater_d = 1'b1;
		end else if (air_s1 >= air_limit) begin
			heater_d = 1'b0;
		end

		// fan
		if (last_rel_q != release_s1) begin
			last_rel_d   = release_s1;
			fan_active_d = 1'b1;
		end
		if (!release_s1 || walarm_d) begin
			fan_active_d = 1'b0;
			fspeed_d     = 2'(FAN_OFF);
		end else if (fan_active_d) begin
			if (water_plus <= wlim_ext && fspeed_q != target) begin
				if (fcnt_q > FAN_DEBOUNCE)
					fspeed_d = target;
				else
					fcnt_d = fcnt_q + 1'b1;
			end else begin
				fcnt_d = '0;
			end
		end else if (water_plus < wlim_ext) begin
			fan_active_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walarm_q     <= 1'b0;
			wcnt_q       <= '0;
			halarm_q     <= 1'b0;
			hcnt_q       <= '0;
			heater_q     <= 1'b0;
			fan_active_q <= 1'b0;
			last_rel_q   <= 1'b0;
			fspeed_q     <= 2'(FAN_OFF);
			fcnt_q       <= '0;
		end else if (advance) begin
			walarm_q     <= walarm_d;
			wcnt_q       <= wcnt_d;
			halarm_q     <= halarm_d;
			hcnt_q       <= hcnt_d;
			heater_q     <= heater_d;
			fan_active_q <= fan_active_d;
			last_rel_q   <= last_rel_d;
			fspeed_q     <= fspeed_d;
			fcnt_q       <= fcnt_d;
		end
	end

	// result register
	logic release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (~out_valid_q | out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			release_q <= release_s1;
	end

	assign out_valid     = out_valid_q;
	assign heater_on     = heater_q;
	assign fan_speed     = fspeed_q;
	assign water_pump_on = walarm_q | release_q;
	assign air_motor_on  = release_q;
	assign water_alarm   = walarm_q;
	assign heat_alarm    = halarm_q;

endmodule

@@ hw/rtl/hftc_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the heater / fan thermal controller, bound to the top level.
// Uses only the top-level ports; no package dependency.
module hftc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        heater_on,
	input logic [1:0]  fan_speed,
	input logic        water_pump_on,
	input logic        air_motor_on,
	input logic        water_alarm,
	input logic        heat_alarm
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fan_speed) && $stable(heater_on)
			&& $stable(water_alarm) && $stable(heat_alarm))
		else $error("result changed while stalled");

	// pump follows release or the water alarm
	a_pump: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> water_pump_on == (water_alarm | air_motor_on))
		else $error("pump output inconsistent");

	// heater is never on under an air alarm
	a_heater: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && heater_on |-> !heat_alarm)
		else $error("heater on during heat alarm");

	// fan only runs with release on and no water alarm
	a_fan: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fan_speed != 2'd0 |-> air_motor_on && !water_alarm)
		else $error("fan running while it should be off");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind heater_fan_thermal_controller_core hftc_checker u_hftc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.pready        (pready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.heater_on     (heater_on),
	.fan_speed     (fan_speed),
	.water_pump_on (water_pump_on),
	.air_motor_on  (air_motor_on),
	.water_alarm   (water_alarm),
	.heat_alarm    (heat_alarm)
);
